FILE: sv/jss_pkg.sv
// shared constants, register codes and types of the joystick servo smoother
package jss_pkg;

  // default parameter values
  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned DUTY_BITS_DEF = 13;

  // fixed field widths
  localparam int unsigned ADC_W      = 12;
  localparam int unsigned LIM_W      = 13;
  localparam int unsigned BAND_W     = 11;
  localparam int unsigned GATE_W     = 8;
  localparam int unsigned SETTLE_W   = 4;
  localparam int unsigned SNAP_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // stick mapping and filter constants
  localparam int unsigned ADC_LO      = 100;
  localparam int unsigned ADC_HI      = 4000;
  localparam int unsigned ADC_CENTRE  = 2050;
  localparam int unsigned ADC_SPAN    = ADC_HI - ADC_LO;
  localparam int unsigned START_DUTY  = 820;
  localparam int unsigned ALPHA_NUM   = 51;
  localparam int unsigned ALPHA_SHIFT = 8;
  localparam int unsigned ALPHA_W     = 7;

  // divide by the stick span through a reciprocal multiply
  localparam int unsigned PROD_MAG_W  = 25;
  localparam int unsigned RECIP_SHIFT = 37;
  localparam int unsigned RECIP_W     = 26;
  localparam int unsigned QUOT_W      = 14;
  localparam longint unsigned RECIP_MUL =
    ((64'd1 << RECIP_SHIFT) + ADC_SPAN - 1) / ADC_SPAN;

  // register reset values
  localparam int unsigned LIMIT_LOW_RST    = 533;
  localparam int unsigned LIMIT_HIGH_RST   = 738;
  localparam int unsigned DEAD_BAND_RST    = 150;
  localparam int unsigned MOVE_GATE_RST    = 5;
  localparam int unsigned SETTLE_TICKS_RST = 3;
  localparam int unsigned SNAP_BAND_RST    = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMIT_LOW_X  = 3'd0,
    REG_LIMIT_HIGH_X = 3'd1,
    REG_LIMIT_LOW_Y  = 3'd2,
    REG_LIMIT_HIGH_Y = 3'd3,
    REG_DEAD_BAND    = 3'd4,
    REG_MOVE_GATE    = 3'd5,
    REG_SETTLE_TICKS = 3'd6,
    REG_SNAP_BAND    = 3'd7
  } cfg_reg_e;

  // settings common to both lanes
  typedef struct packed {
    logic [BAND_W-1:0]   dead_band;
    logic [GATE_W-1:0]   move_gate;
    logic [SETTLE_W-1:0] settle_ticks;
    logic [SNAP_W-1:0]   snap_band;
  } shared_cfg_t;

  // step strobes from the sequencer to the lanes
  typedef struct packed {
    logic load;
    logic div;
    logic clamp;
    logic filt;
    logic commit;
  } lane_ctrl_t;

endpackage

FILE: sv/jss_if.sv
// handshake interfaces of the stick input, servo output and configuration channels

// stick sample channel
interface jss_stick_if import jss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] stick_x;
  logic [ADC_W-1:0] stick_y;

  modport source (output valid, output stick_x, output stick_y, input ready);
  modport sink   (input valid, input stick_x, input stick_y, output ready);
endinterface

// servo result channel
interface jss_servo_if import jss_pkg::*; #(
  parameter int unsigned DUTY_BITS = DUTY_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [DUTY_BITS-1:0] duty_x;
  logic                 write_x;
  logic                 on_x;
  logic [DUTY_BITS-1:0] duty_y;
  logic                 write_y;
  logic                 on_y;

  modport source (output valid, output duty_x, output write_x, output on_x,
                  output duty_y, output write_y, output on_y, input ready);
  modport sink   (input valid, input duty_x, input write_x, input on_x,
                  input duty_y, input write_y, input on_y, output ready);
endinterface

// register write channel
interface jss_cfg_if import jss_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/jss_lane.sv
// one axis lane: deadzone, inverse map, clamp, exponential filter and write gate
module jss_lane import jss_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned DUTY_BITS = DUTY_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lane_ctrl_t           ctrl_i,
  input  logic [ADC_W-1:0]     stick_i,
  input  logic [LIM_W-1:0]     limit_low_i,
  input  logic [LIM_W-1:0]     limit_high_i,
  input  shared_cfg_t          cfg_i,
  output logic [DUTY_BITS-1:0] duty_o,
  output logic                 write_o,
  output logic                 on_o
);

  localparam int unsigned POS_W  = LIM_W + FRAC_BITS;
  localparam int unsigned PROD_W = ADC_W + LIM_W + 2;
  localparam int unsigned TSUM_W = QUOT_W + 2;
  localparam int unsigned STEP_W = POS_W + ALPHA_W;

  // deadzone and signed product of offset and span
  logic signed [ADC_W:0]    ctr_diff;
  logic [ADC_W-1:0]         ctr_dist;
  logic [ADC_W-1:0]         stick_dz;
  logic signed [ADC_W:0]    stick_off;
  logic signed [LIM_W:0]    span;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_MAG_W-1:0]    mag_q;
  logic                     neg_q;

  always_comb begin
    ctr_diff  = $signed({1'b0, stick_i}) - $signed((ADC_W + 1)'(ADC_CENTRE));
    ctr_dist  = ADC_W'(ctr_diff[ADC_W] ? -ctr_diff : ctr_diff);
    stick_dz  = (ctr_dist < ADC_W'(cfg_i.dead_band)) ? ADC_W'(ADC_CENTRE) : stick_i;
    stick_off = $signed({1'b0, stick_dz}) - $signed((ADC_W + 1)'(ADC_LO));
    span      = $signed({1'b0, limit_low_i}) - $signed({1'b0, limit_high_i});
    prod      = PROD_W'(stick_off) * PROD_W'(span);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mag_q <= PROD_MAG_W'(prod[PROD_W-1] ? -prod : prod);
      neg_q <= prod[PROD_W-1];
    end
  end

  // quotient by the stick span, truncated toward zero
  logic [PROD_MAG_W+RECIP_W-1:0] quot_prod;
  logic [QUOT_W-1:0]             quot_q;
  logic                          qneg_q;

  assign quot_prod = (PROD_MAG_W + RECIP_W)'(mag_q) * (PROD_MAG_W + RECIP_W)'(RECIP_MUL);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div) begin
      quot_q <= quot_prod[RECIP_SHIFT +: QUOT_W];
      qneg_q <= neg_q;
    end
  end

  // offset from the high limit and clamp to the limit span
  logic signed [TSUM_W-1:0] tsum;
  logic signed [TSUM_W-1:0] quot_s;
  logic [LIM_W-1:0]         clamp_lo;
  logic [LIM_W-1:0]         clamp_hi;
  logic [LIM_W-1:0]         tgt_q;

  always_comb begin
    quot_s   = $signed(TSUM_W'(quot_q));
    tsum     = $signed(TSUM_W'(limit_high_i)) + (qneg_q ? -quot_s : quot_s);
    clamp_lo = (limit_high_i < limit_low_i) ? limit_high_i : limit_low_i;
    clamp_hi = (limit_high_i < limit_low_i) ? limit_low_i : limit_high_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clamp) begin
      if (tsum < $signed(TSUM_W'(clamp_lo))) begin
        tgt_q <= clamp_lo;
      end else if (tsum > $signed(TSUM_W'(clamp_hi))) begin
        tgt_q <= clamp_hi;
      end else begin
        tgt_q <= tsum[LIM_W-1:0];
      end
    end
  end

  // exponential filter with snap to target
  logic [POS_W-1:0]         pos_q, pos_d;
  logic [POS_W-1:0]         tgt_fix;
  logic signed [POS_W:0]    fdiff;
  logic [POS_W-1:0]         fdist;
  logic signed [STEP_W-1:0] step_raw;
  logic signed [STEP_W-1:0] step;
  logic signed [STEP_W-1:0] pos_sum;

  always_comb begin
    tgt_fix  = {tgt_q, FRAC_BITS'(0)};
    fdiff    = $signed({1'b0, tgt_fix}) - $signed({1'b0, pos_q});
    fdist    = POS_W'(fdiff[POS_W] ? -fdiff : fdiff);
    step_raw = STEP_W'(fdiff) * $signed(STEP_W'(ALPHA_NUM));
    step     = step_raw >>> ALPHA_SHIFT;
    pos_sum  = $signed(STEP_W'(pos_q)) + step;
    if (fdist < POS_W'({cfg_i.snap_band, FRAC_BITS'(0)})) begin
      pos_d = tgt_fix;
    end else begin
      pos_d = pos_sum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_W'(START_DUTY) << FRAC_BITS;
    end else if (ctrl_i.filt) begin
      pos_q <= pos_d;
    end
  end

  // write gate and channel enable
  logic [DUTY_BITS-1:0]       duty;
  logic [DUTY_BITS-1:0]       last_q;
  logic                       written_q;
  logic [SETTLE_W-1:0]        settle_q;
  logic                       on_q;
  logic signed [DUTY_BITS:0]  wdiff;
  logic [DUTY_BITS:0]         wdist;
  logic                       moved;
  logic                       settling;

  always_comb begin
    duty     = DUTY_BITS'(pos_q[POS_W-1:FRAC_BITS]);
    wdiff    = $signed({1'b0, duty}) - $signed({1'b0, last_q});
    wdist    = (DUTY_BITS + 1)'(wdiff[DUTY_BITS] ? -wdiff : wdiff);
    moved    = !written_q || (wdist >= (DUTY_BITS + 1)'(cfg_i.move_gate));
    settling = settle_q < cfg_i.settle_ticks;
    duty_o   = duty;
    write_o  = moved || settling;
    on_o     = moved || (settling && on_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= 1'b0;
      settle_q  <= '0;
      on_q      <= 1'b1;
    end else if (ctrl_i.commit) begin
      if (moved) begin
        written_q <= 1'b1;
        settle_q  <= '0;
        on_q      <= 1'b1;
      end else if (settling) begin
        settle_q  <= settle_q + SETTLE_W'(1);
      end else begin
        on_q      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && moved) begin
      last_q <= duty;
    end
  end

endmodule

FILE: sv/jss_merge.sv
// merging stage: joins both lane results into one output beat and holds it
module jss_merge import jss_pkg::*; #(
  parameter int unsigned DUTY_BITS = DUTY_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 commit_i,
  input  logic [DUTY_BITS-1:0] duty_x_i,
  input  logic                 write_x_i,
  input  logic                 on_x_i,
  input  logic [DUTY_BITS-1:0] duty_y_i,
  input  logic                 write_y_i,
  input  logic                 on_y_i,
  output logic                 slot_free_o,
  jss_servo_if.source          servo_o
);

  logic                 valid_q, valid_d;
  logic [DUTY_BITS-1:0] duty_x_q, duty_y_q;
  logic                 write_x_q, on_x_q, write_y_q, on_y_q;

  // slot opens when empty or being drained this cycle
  assign slot_free_o = !valid_q || servo_o.ready;
  assign valid_d     = commit_i || (valid_q && !servo_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (commit_i) begin
      duty_x_q  <= duty_x_i;
      write_x_q <= write_x_i;
      on_x_q    <= on_x_i;
      duty_y_q  <= duty_y_i;
      write_y_q <= write_y_i;
      on_y_q    <= on_y_i;
    end
  end

  assign servo_o.valid   = valid_q;
  assign servo_o.duty_x  = duty_x_q;
  assign servo_o.write_x = write_x_q;
  assign servo_o.on_x    = on_x_q;
  assign servo_o.duty_y  = duty_y_q;
  assign servo_o.write_y = write_y_q;
  assign servo_o.on_y    = on_y_q;

endmodule

FILE: sv/joystick_servo_smoother_core.sv
// top level of the joystick servo smoother: registers, sequencer, two lanes, merge
//
// Each stick beat carries one X and one Y sample; both axes are worked on at once
// by two identical lanes and their results leave together as one servo beat.
// An item is carried from its acceptance to the output register through the
// reciprocal multiply that divides by the stick span, the limit clamp, the
// filter update and the write gate, stepped by one sequencer shared by both
// lanes. A new sample is accepted in the gate cycle of the previous one, so the
// block takes the next item while the last is still in its gate step; a held
// output beat stalls the gate step until it drains. Register writes are taken in
// any cycle and must only be issued while no item is in flight. The X and Y
// channels start enabled, with the filter at duty 820 and the first tick always
// written.
module joystick_servo_smoother_core import jss_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned DUTY_BITS = DUTY_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  jss_stick_if.sink   stick_i,
  jss_servo_if.source servo_o,
  jss_cfg_if.sink     cfg_i
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_CLAMP = 5'b00100,
    ST_FILT  = 5'b01000,
    ST_GATE  = 5'b10000
  } state_e;

  // configuration registers
  logic [LIM_W-1:0] limit_low_x_q, limit_high_x_q, limit_low_y_q, limit_high_y_q;
  shared_cfg_t      shared_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_low_x_q         <= LIM_W'(LIMIT_LOW_RST);
      limit_high_x_q        <= LIM_W'(LIMIT_HIGH_RST);
      limit_low_y_q         <= LIM_W'(LIMIT_LOW_RST);
      limit_high_y_q        <= LIM_W'(LIMIT_HIGH_RST);
      shared_q.dead_band    <= BAND_W'(DEAD_BAND_RST);
      shared_q.move_gate    <= GATE_W'(MOVE_GATE_RST);
      shared_q.settle_ticks <= SETTLE_W'(SETTLE_TICKS_RST);
      shared_q.snap_band    <= SNAP_W'(SNAP_BAND_RST);
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_LIMIT_LOW_X:  limit_low_x_q         <= cfg_i.data[LIM_W-1:0];
        REG_LIMIT_HIGH_X: limit_high_x_q        <= cfg_i.data[LIM_W-1:0];
        REG_LIMIT_LOW_Y:  limit_low_y_q         <= cfg_i.data[LIM_W-1:0];
        REG_LIMIT_HIGH_Y: limit_high_y_q        <= cfg_i.data[LIM_W-1:0];
        REG_DEAD_BAND:    shared_q.dead_band    <= cfg_i.data[BAND_W-1:0];
        REG_MOVE_GATE:    shared_q.move_gate    <= cfg_i.data[GATE_W-1:0];
        REG_SETTLE_TICKS: shared_q.settle_ticks <= cfg_i.data[SETTLE_W-1:0];
        REG_SNAP_BAND:    shared_q.snap_band    <= cfg_i.data[SNAP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer shared by both lanes
  state_e     state_q, state_d;
  logic       slot_free;
  logic       accept;
  lane_ctrl_t ctrl;

  assign stick_i.ready = (state_q == ST_IDLE) || ((state_q == ST_GATE) && slot_free);
  assign accept        = stick_i.valid && stick_i.ready;

  always_comb begin
    ctrl.load   = accept;
    ctrl.div    = (state_q == ST_DIV);
    ctrl.clamp  = (state_q == ST_CLAMP);
    ctrl.filt   = (state_q == ST_FILT);
    ctrl.commit = (state_q == ST_GATE) && slot_free;
    state_d     = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_DIV;
      ST_DIV:   state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_FILT;
      ST_FILT:  state_d = ST_GATE;
      ST_GATE: begin
        if (slot_free) begin
          state_d = accept ? ST_DIV : ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // axis lanes
  logic [DUTY_BITS-1:0] duty_x, duty_y;
  logic                 write_x, on_x, write_y, on_y;

  jss_lane #(
    .FRAC_BITS (FRAC_BITS),
    .DUTY_BITS (DUTY_BITS)
  ) u_lane_x (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stick_i      (stick_i.stick_x),
    .limit_low_i  (limit_low_x_q),
    .limit_high_i (limit_high_x_q),
    .cfg_i        (shared_q),
    .duty_o       (duty_x),
    .write_o      (write_x),
    .on_o         (on_x)
  );

  jss_lane #(
    .FRAC_BITS (FRAC_BITS),
    .DUTY_BITS (DUTY_BITS)
  ) u_lane_y (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stick_i      (stick_i.stick_y),
    .limit_low_i  (limit_low_y_q),
    .limit_high_i (limit_high_y_q),
    .cfg_i        (shared_q),
    .duty_o       (duty_y),
    .write_o      (write_y),
    .on_o         (on_y)
  );

  // output beat assembly
  jss_merge #(
    .DUTY_BITS (DUTY_BITS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .commit_i    (ctrl.commit),
    .duty_x_i    (duty_x),
    .write_x_i   (write_x),
    .on_x_i      (on_x),
    .duty_y_i    (duty_y),
    .write_y_i   (write_y),
    .on_y_i      (on_y),
    .slot_free_o (slot_free),
    .servo_o     (servo_o)
  );

endmodule
